@@ hdl/hbrdt_pkg.sv @@
// ----------------------------------------------------------------------------
// hbrdt_pkg
// Shared types and codes for the H-bridge reversal dead-time controller.
// ----------------------------------------------------------------------------
package hbrdt_pkg;

   localparam int unsigned DIR_W    = 2;
   localparam int unsigned MOTION_W = 3;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned DEAD_W   = 16;
   localparam int unsigned DUTY_W   = 8;
   localparam int unsigned CSR_AW   = 2;
   localparam int unsigned CSR_DW   = 16;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   localparam logic [CSR_AW-1:0] CSR_DEAD_TIME   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_DRIVE_DUTY  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_LEFT_INV    = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_RIGHT_INV   = 2'd3;

   localparam logic [DEAD_W-1:0] DEAD_TIME_RESET = 16'd100;
   localparam logic [DUTY_W-1:0] DRIVE_DUTY_RESET = 8'd200;

   localparam logic [DIR_W-1:0]    DIR_OFF     = 2'b00;
   localparam logic [DIR_W-1:0]    DIR_FWD     = 2'b01;
   localparam logic [DIR_W-1:0]    DIR_REV     = 2'b11;
   localparam logic [MOTION_W-1:0] MOTION_IDLE = 3'd0;

   typedef struct packed {
      logic [DEAD_W-1:0] dead_time_ms;
      logic [DUTY_W-1:0] drive_duty;
      logic              left_inverted;
      logic              right_inverted;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [MOTION_W-1:0] requested_motion;
      logic [DIR_W-1:0]    left_dir;
      logic [DIR_W-1:0]    right_dir;
      logic [TIME_W-1:0]   now_ms;
   } item_type;

   typedef struct packed {
      logic [MOTION_W-1:0] applied_motion;
      logic [DIR_W-1:0]    cur_left_dir;
      logic [DIR_W-1:0]    cur_right_dir;
      logic [MOTION_W-1:0] held_motion;
      logic [DIR_W-1:0]    held_left_dir;
      logic [DIR_W-1:0]    held_right_dir;
      logic                pending_flag;
      logic                guard_flag;
      logic [TIME_W-1:0]   stop_time;
      logic [TIME_W-1:0]   reversal_start_time;
   } state_type;

   typedef struct packed {
      logic                reversal_pending;
      logic [MOTION_W-1:0] motion_state;
      logic [DIR_W-1:0]    right_drive;
      logic [DIR_W-1:0]    left_drive;
      logic [DUTY_W-1:0]   pwm_duty;
   } result_type;

   // Any pattern other than off or forward is taken as reverse.
   function automatic logic [DIR_W-1:0] norm_dir(input logic [DIR_W-1:0] d);
      logic [DIR_W-1:0] r;
      r = (d == DIR_OFF || d == DIR_FWD) ? d : DIR_REV;
      return r;
   endfunction

endpackage

@@ hdl/hbridge_reversal_deadtime_control.sv @@
// ----------------------------------------------------------------------------
// hbridge_reversal_deadtime_control
// Dead-time protected direction control for two H-bridge motor sides.
// ----------------------------------------------------------------------------
// Each beat on req is a tick, a run request, a stop or a no-op, and gives exactly one
// beat on rsp, through the input register and then the result register. A new beat is taken
// every cycle while rsp is not stalled; the rate is one item per cycle, set by the state
// update between the input register and the result register. Configuration
// writes through csr take effect on the next cycle.
module hbridge_reversal_deadtime_control
   import hbrdt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,   // opcode
   input  logic [39:0]         req_tdata,   // requested_motion, left_dir, right_dir, now_ms, pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // pwm_duty, left_drive, right_drive,
                                            // motion_state, reversal_pending
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type res_in;
   result_type res_ff;
   logic       res_valid_ff;
   logic       advance;

   assign advance    = item_valid_ff && (!res_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_time_ms   <= DEAD_TIME_RESET;
         cfg_ff.drive_duty     <= DRIVE_DUTY_RESET;
         cfg_ff.left_inverted  <= 1'b0;
         cfg_ff.right_inverted <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEAD_TIME:  cfg_ff.dead_time_ms   <= csr_wdata[DEAD_W-1:0];
            CSR_DRIVE_DUTY: cfg_ff.drive_duty     <= csr_wdata[DUTY_W-1:0];
            CSR_LEFT_INV:   cfg_ff.left_inverted  <= csr_wdata[0];
            CSR_RIGHT_INV:  cfg_ff.right_inverted <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.opcode           <= req_tuser;
         item_ff.requested_motion <= req_tdata[2:0];
         item_ff.left_dir         <= req_tdata[4:3];
         item_ff.right_dir        <= req_tdata[6:5];
         item_ff.now_ms           <= req_tdata[38:7];
      end
   end

   hbrdt_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         res_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   a_pending_coasts: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending_flag |-> state_ff.applied_motion == MOTION_IDLE)
      else $error("held reversal while a motion is applied");

   a_guard_excl: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.pending_flag && state_ff.guard_flag))
      else $error("guard and held reversal both set");

   a_pending_zero_duty: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_ff.reversal_pending |-> res_ff.pwm_duty == '0)
      else $error("duty driven during a held reversal");

endmodule

@@ hdl/hbrdt_step.sv @@
// ----------------------------------------------------------------------------
// hbrdt_step
// Next-state and result logic for one item of the reversal controller.
// ----------------------------------------------------------------------------
module hbrdt_step
   import hbrdt_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  cur,
   input  item_type   item,
   output state_type  nxt,
   output result_type res
);

   logic [DIR_W-1:0] l_dir;
   logic [DIR_W-1:0] r_dir;
   logic [TIME_W-1:0] since_stop;
   logic [TIME_W-1:0] since_rev;
   logic guard_done;
   logic rev_done;
   logic guard_keep;
   logic [DIR_W-1:0] kl_dir;
   logic [DIR_W-1:0] kr_dir;
   logic reverses;
   logic active;
   logic is_stop;
   logic on;
   logic [DIR_W-1:0] pl_dir;
   logic [DIR_W-1:0] pr_dir;

   assign l_dir      = norm_dir(item.left_dir);
   assign r_dir      = norm_dir(item.right_dir);
   assign since_stop = item.now_ms - cur.stop_time;
   assign since_rev  = item.now_ms - cur.reversal_start_time;
   assign guard_done = cur.guard_flag &&
                       (since_stop >= {{(TIME_W-DEAD_W){1'b0}}, cfg.dead_time_ms});
   assign rev_done   = since_rev >= {{(TIME_W-DEAD_W){1'b0}}, cfg.dead_time_ms};
   assign guard_keep = cur.guard_flag && !guard_done;
   assign kl_dir     = guard_done ? DIR_OFF : cur.cur_left_dir;
   assign kr_dir     = guard_done ? DIR_OFF : cur.cur_right_dir;
   assign reverses   = (kl_dir != DIR_OFF && l_dir != kl_dir) ||
                       (kr_dir != DIR_OFF && r_dir != kr_dir);
   assign active     = cur.applied_motion != MOTION_IDLE || cur.pending_flag;
   assign is_stop    = item.opcode == OP_STOP ||
                       (item.opcode == OP_RUN && item.requested_motion == MOTION_IDLE);

   always_comb begin
      nxt = cur;
      if (is_stop) begin
         if (active && (cur.cur_left_dir != DIR_OFF || cur.cur_right_dir != DIR_OFF)) begin
            nxt.stop_time  = item.now_ms;
            nxt.guard_flag = 1'b1;
         end
         nxt.pending_flag   = 1'b0;
         nxt.held_motion    = MOTION_IDLE;
         nxt.held_left_dir  = DIR_OFF;
         nxt.held_right_dir = DIR_OFF;
         nxt.applied_motion = MOTION_IDLE;
      end else if (item.opcode == OP_RUN) begin
         nxt.cur_left_dir  = kl_dir;
         nxt.cur_right_dir = kr_dir;
         nxt.guard_flag    = 1'b0;
         if (!reverses) begin
            nxt.cur_left_dir   = l_dir;
            nxt.cur_right_dir  = r_dir;
            nxt.pending_flag   = 1'b0;
            nxt.held_motion    = MOTION_IDLE;
            nxt.held_left_dir  = DIR_OFF;
            nxt.held_right_dir = DIR_OFF;
            nxt.applied_motion = item.requested_motion;
         end else begin
            nxt.applied_motion = MOTION_IDLE;
            if (!cur.pending_flag) begin
               nxt.reversal_start_time = guard_keep ? cur.stop_time : item.now_ms;
            end
            nxt.held_motion    = item.requested_motion;
            nxt.held_left_dir  = l_dir;
            nxt.held_right_dir = r_dir;
            nxt.pending_flag   = 1'b1;
         end
      end else if (item.opcode == OP_TICK) begin
         if (cur.pending_flag && rev_done) begin
            nxt.cur_left_dir   = cur.held_left_dir;
            nxt.cur_right_dir  = cur.held_right_dir;
            nxt.guard_flag     = 1'b0;
            nxt.pending_flag   = 1'b0;
            nxt.held_motion    = MOTION_IDLE;
            nxt.held_left_dir  = DIR_OFF;
            nxt.held_right_dir = DIR_OFF;
            nxt.applied_motion = cur.held_motion;
         end
      end
   end

   assign on     = nxt.applied_motion != MOTION_IDLE;
   assign pl_dir = cfg.left_inverted  ? DIR_W'(2'b00 - nxt.cur_left_dir)  : nxt.cur_left_dir;
   assign pr_dir = cfg.right_inverted ? DIR_W'(2'b00 - nxt.cur_right_dir) : nxt.cur_right_dir;

   always_comb begin
      res.pwm_duty         = on ? cfg.drive_duty : '0;
      res.left_drive       = on ? pl_dir : DIR_OFF;
      res.right_drive      = on ? pr_dir : DIR_OFF;
      res.motion_state     = nxt.applied_motion;
      res.reversal_pending = nxt.pending_flag;
   end

endmodule

@@ tb/sv/tb_hbridge_reversal_deadtime_control.sv @@
// ----------------------------------------------------------------------------
// tb_hbridge_reversal_deadtime_control
// Self-checking testbench for the H-bridge reversal dead-time controller.
// ----------------------------------------------------------------------------
// Ticks, run requests, stops and no-ops are sent; in the random traffic they come with random
// gaps while the result side stalls at random. A behavioral model of the dead-time logic predicts
// every result beat, and each beat is checked field by field in order. The
// run covers directed reversal, guard and wrap cases, then random command
// traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_hbridge_reversal_deadtime_control
   import hbrdt_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [MOTION_W-1:0] motion;
      logic [DIR_W-1:0]    left;
      logic [DIR_W-1:0]    right;
      logic [MOTION_W-1:0] queued_motion;
      logic [DIR_W-1:0]    queued_left;
      logic [DIR_W-1:0]    queued_right;
      bit                  waiting;
      bit                  coasting;
      logic [TIME_W-1:0]   halt_at;
      logic [TIME_W-1:0]   coast_from;
   } bridge_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [1:0]        req_tuser = OP_TICK;
   logic [39:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b1;
   logic [15:0]       rsp_tdata;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = CSR_DEAD_TIME;
   logic [CSR_DW-1:0] csr_wdata = '0;

   bridge_type        bridge;
   cfg_type           csr_shadow;
   result_type        drive_q[$];
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   bit                gaps_on = 1'b0;
   bit                stalls_on = 1'b0;
   int unsigned       stall_left = 0;
   logic [TIME_W-1:0] clock_ms = 32'd0;

   hbridge_reversal_deadtime_control u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int unsigned pick_len();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 70) return $urandom_range(1, 2);
      if (k < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   function automatic bit dead_time_over(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] since);
      logic [TIME_W-1:0] span;
      span = now - since;
      return span >= {16'd0, csr_shadow.dead_time_ms};
   endfunction

   task automatic engage(input logic [MOTION_W-1:0] m, input logic [DIR_W-1:0] l,
                         input logic [DIR_W-1:0] r);
      bridge.left          = l;
      bridge.right         = r;
      bridge.coasting      = 1'b0;
      bridge.waiting       = 1'b0;
      bridge.queued_motion = MOTION_IDLE;
      bridge.queued_left   = DIR_OFF;
      bridge.queued_right  = DIR_OFF;
      bridge.motion        = m;
   endtask

   task automatic halt_bridge(input logic [TIME_W-1:0] now);
      if ((bridge.motion != MOTION_IDLE || bridge.waiting) &&
          (bridge.left != DIR_OFF || bridge.right != DIR_OFF)) begin
         bridge.halt_at  = now;
         bridge.coasting = 1'b1;
      end
      bridge.waiting       = 1'b0;
      bridge.queued_motion = MOTION_IDLE;
      bridge.queued_left   = DIR_OFF;
      bridge.queued_right  = DIR_OFF;
      bridge.motion        = MOTION_IDLE;
   endtask

   task automatic request_motion(input logic [MOTION_W-1:0] m, input logic [DIR_W-1:0] l,
                                 input logic [DIR_W-1:0] r, input logic [TIME_W-1:0] now);
      bit flips;
      if (bridge.coasting && dead_time_over(now, bridge.halt_at)) begin
         bridge.coasting = 1'b0;
         bridge.left     = DIR_OFF;
         bridge.right    = DIR_OFF;
      end
      flips = (bridge.left != DIR_OFF && l != bridge.left) ||
              (bridge.right != DIR_OFF && r != bridge.right);
      if (!flips) begin
         engage(m, l, r);
      end else begin
         bridge.motion = MOTION_IDLE;
         if (!bridge.waiting) begin
            bridge.coast_from = bridge.coasting ? bridge.halt_at : now;
         end
         bridge.coasting      = 1'b0;
         bridge.queued_motion = m;
         bridge.queued_left   = l;
         bridge.queued_right  = r;
         bridge.waiting       = 1'b1;
      end
   endtask

   // Advances the model by one command and returns the drive it should show.
   task automatic predict_drive(input logic [1:0] op, input logic [MOTION_W-1:0] m,
                                input logic [DIR_W-1:0] lb, input logic [DIR_W-1:0] rb,
                                input logic [TIME_W-1:0] now, output result_type res);
      logic [DIR_W-1:0] l;
      logic [DIR_W-1:0] r;
      bit               on;
      l = (lb == 2'b10) ? DIR_REV : lb;
      r = (rb == 2'b10) ? DIR_REV : rb;
      case (op)
         OP_TICK: begin
            if (bridge.waiting && dead_time_over(now, bridge.coast_from)) begin
               engage(bridge.queued_motion, bridge.queued_left, bridge.queued_right);
            end
         end
         OP_RUN: begin
            if (m == MOTION_IDLE) halt_bridge(now);
            else request_motion(m, l, r, now);
         end
         OP_STOP: begin
            halt_bridge(now);
         end
         default: begin
         end
      endcase
      on = bridge.motion != MOTION_IDLE;
      res.pwm_duty         = on ? csr_shadow.drive_duty : '0;
      res.left_drive       = !on ? DIR_OFF :
                             (csr_shadow.left_inverted ? -bridge.left : bridge.left);
      res.right_drive      = !on ? DIR_OFF :
                             (csr_shadow.right_inverted ? -bridge.right : bridge.right);
      res.motion_state     = bridge.motion;
      res.reversal_pending = bridge.waiting;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 20) begin
         stall_left = pick_len() - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (drive_q.size() == 0) begin
            report_mismatch("unexpected result beat", 0, rsp_tdata);
         end else begin
            want = drive_q.pop_front();
            if (got.pwm_duty != want.pwm_duty)
               report_mismatch("pwm_duty", want.pwm_duty, got.pwm_duty);
            if (got.left_drive != want.left_drive)
               report_mismatch("left_drive", want.left_drive, got.left_drive);
            if (got.right_drive != want.right_drive)
               report_mismatch("right_drive", want.right_drive, got.right_drive);
            if (got.motion_state != want.motion_state)
               report_mismatch("motion_state", want.motion_state, got.motion_state);
            if (got.reversal_pending != want.reversal_pending)
               report_mismatch("reversal_pending", want.reversal_pending,
                               got.reversal_pending);
         end
      end
   end

   // Starts and ends at a falling edge; valid stays high after the beat.
   task automatic send_command(input logic [1:0] op, input logic [MOTION_W-1:0] m,
                               input logic [DIR_W-1:0] lb, input logic [DIR_W-1:0] rb,
                               input logic [TIME_W-1:0] now);
      int unsigned gap;
      result_type  res;
      gap = (gaps_on && $urandom_range(0, 99) < 30) ? pick_len() : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {1'b0, now, rb, lb, m};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_drive(op, m, lb, rb, now, res);
      drive_q.push_back(res);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (drive_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] value);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         CSR_DEAD_TIME:  csr_shadow.dead_time_ms   = value;
         CSR_DRIVE_DUTY: csr_shadow.drive_duty     = value[DUTY_W-1:0];
         CSR_LEFT_INV:   csr_shadow.left_inverted  = value[0];
         default:        csr_shadow.right_inverted = value[0];
      endcase
   endtask

   task automatic set_drive_config(input logic [DEAD_W-1:0] dead, input logic [DUTY_W-1:0] duty,
                                   input bit linv, input bit rinv);
      wait_drained();
      write_csr(CSR_DEAD_TIME, dead);
      write_csr(CSR_DRIVE_DUTY, {8'd0, duty});
      write_csr(CSR_LEFT_INV, {15'd0, linv});
      write_csr(CSR_RIGHT_INV, {15'd0, rinv});
   endtask

   task automatic test_directed_sequence();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_command(OP_TICK, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'd1000);
      send_command(OP_RUN, 3'd1, DIR_FWD, DIR_FWD, 32'd1000);
      send_command(OP_RUN, 3'd2, DIR_REV, DIR_REV, 32'd1010);
      send_command(OP_TICK, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'd1050);
      send_command(OP_RUN, 3'd2, DIR_REV, DIR_REV, 32'd1060);
      send_command(OP_TICK, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'd1110);
      send_command(OP_STOP, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'd1120);
      send_command(OP_RUN, 3'd1, DIR_FWD, DIR_FWD, 32'd1130);
      send_command(OP_TICK, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'd1220);
      send_command(OP_STOP, 3'd7, DIR_REV, DIR_FWD, 32'd1230);
      send_command(OP_RUN, 3'd1, DIR_FWD, DIR_FWD, 32'd1400);
      send_command(OP_RUN, MOTION_IDLE, DIR_FWD, DIR_REV, 32'd1410);
      // A direction pattern of two reads as reverse.
      send_command(OP_RUN, 3'd3, 2'b10, DIR_FWD, 32'd1600);
      send_command(OP_RUN, 3'd4, DIR_FWD, 2'b10, 32'd1601);
      send_command(OP_NOP, 3'd7, 2'b11, 2'b11, 32'hFFFF_FFFF);
      send_command(OP_TICK, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'd1701);
      send_command(OP_RUN, 3'd7, DIR_FWD, DIR_REV, 32'd1702);
      send_command(OP_RUN, 3'd5, DIR_OFF, DIR_OFF, 32'd1703);
      send_command(OP_RUN, 3'd6, DIR_REV, DIR_OFF, 32'd1704);
   endtask

   task automatic test_config_extremes();
      // Zero dead time still holds a reversal until the next tick.
      set_drive_config(16'd0, 8'd255, 1'b1, 1'b1);
      send_command(OP_RUN, 3'd1, DIR_FWD, DIR_FWD, 32'd5000);
      send_command(OP_RUN, 3'd2, DIR_REV, DIR_REV, 32'd5000);
      send_command(OP_TICK, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'd5000);
      // The longest dead time across the timestamp wrap.
      set_drive_config(16'hFFFF, 8'd0, 1'b0, 1'b1);
      send_command(OP_RUN, 3'd3, DIR_REV, DIR_FWD, 32'hFFFF_FF00);
      send_command(OP_RUN, 3'd4, DIR_FWD, DIR_REV, 32'hFFFF_FF10);
      send_command(OP_TICK, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'h0000_FF00);
      send_command(OP_TICK, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'h0001_0000);
      send_command(OP_STOP, MOTION_IDLE, DIR_OFF, DIR_OFF, 32'h0001_0001);
   endtask

   task automatic random_command(input logic [DEAD_W-1:0] dead);
      int unsigned       k;
      logic [1:0]        op;
      logic [MOTION_W-1:0] m;
      logic [DIR_W-1:0]  l;
      logic [DIR_W-1:0]  r;
      k = $urandom_range(0, 99);
      if (k < 55) clock_ms += $urandom_range(0, dead / 4 + 2);
      else if (k < 85) clock_ms += (dead < 2) ? $urandom_range(0, 3)
                                              : $urandom_range(dead - 2, dead + 2);
      else if (k < 95) clock_ms += $urandom_range(0, 3 * dead + 5);
      else clock_ms = $urandom;
      k = $urandom_range(0, 99);
      m = MOTION_IDLE;
      l = DIR_OFF;
      r = DIR_OFF;
      if (k < 35) begin
         op = OP_TICK;
      end else if (k < 75) begin
         op = OP_RUN;
         m  = MOTION_W'($urandom_range(1, 4));
         case (m)
            3'd1: begin l = DIR_FWD; r = DIR_FWD; end
            3'd2: begin l = DIR_REV; r = DIR_REV; end
            3'd3: begin l = DIR_REV; r = DIR_FWD; end
            default: begin l = DIR_FWD; r = DIR_REV; end
         endcase
         if (l == DIR_REV && $urandom_range(0, 9) == 0) l = 2'b10;
         if (r == DIR_REV && $urandom_range(0, 9) == 0) r = 2'b10;
      end else if (k < 88) begin
         op = OP_STOP;
      end else begin
         op = 2'($urandom_range(0, 3));
         m  = MOTION_W'($urandom_range(0, 7));
         l  = DIR_W'($urandom_range(0, 3));
         r  = DIR_W'($urandom_range(0, 3));
      end
      send_command(op, m, l, r, clock_ms);
   endtask

   task automatic test_random_traffic();
      int unsigned i;
      int unsigned phase;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_drive_config(DEAD_TIME_RESET, DRIVE_DUTY_RESET, 1'b0, 1'b0);
            1: set_drive_config(16'd0, 8'd255, 1'b1, 1'b0);
            2: set_drive_config(16'hFFFF, 8'd0, 1'b0, 1'b1);
            3: set_drive_config(16'd1, 8'd1, 1'b1, 1'b1);
            default: set_drive_config(DEAD_W'($urandom_range(2, 500)),
                                      DUTY_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         for (i = 0; i < 255; i++) begin
            if (i % 64 == 0) begin
               gaps_on   = $urandom_range(0, 3) != 0;
               stalls_on = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 99) < 2) wait_drained();
            random_command(csr_shadow.dead_time_ms);
         end
      end
   endtask

   initial begin
      bridge                    = '{default: '0};
      csr_shadow.dead_time_ms   = DEAD_TIME_RESET;
      csr_shadow.drive_duty     = DRIVE_DUTY_RESET;
      csr_shadow.left_inverted  = 1'b0;
      csr_shadow.right_inverted = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_sequence();
      wait_drained();
      test_config_extremes();
      test_random_traffic();
      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
